@@ design/e2r_pkg.sv @@
package e2r_pkg;

    // Field widths.
    localparam int ANGLE_BITS   = 16;
    localparam int ELEMENT_BITS = 16;
    localparam int TRIG_STEPS   = 16;

    localparam int AFRAC = ANGLE_BITS - 3;
    localparam int EFRAC = ELEMENT_BITS - 2;

    // Internal Q2.30 arithmetic.
    localparam int QF     = 30;
    localparam int QW     = QF + 2;
    localparam int ASHIFT = QF - AFRAC;
    localparam int FW     = ANGLE_BITS + ASHIFT + 1;
    localparam int TW     = QF + 1;
    localparam int XW     = QF + 2;
    localparam int NW     = TW + XW - QF;
    localparam int SW     = QW + 1;
    localparam int ESH    = QF - EFRAC;

    // Exact division by a small constant through a scaled reciprocal.
    // The divisor stays below 2^DW, so a shift of NW + DW bits is exact.
    localparam int DW  = 12;
    localparam int RSH = NW + DW;
    localparam int RW  = RSH;
    localparam int RLO = (RW + 1) / 2;
    localparam int RHI = RW - RLO;

    localparam logic signed [FW-1:0] Q_PI      = FW'(64'd3373259426);
    localparam logic signed [FW-1:0] Q_HALF_PI = FW'(64'd1686629713);
    localparam logic [TW-1:0]        Q_ONE     = TW'(64'd1 << QF);
    localparam int                   ELEM_ONE  = 1 << EFRAC;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
    } t_request;

    typedef struct packed {
        logic signed [ELEMENT_BITS-1:0] m00;
        logic signed [ELEMENT_BITS-1:0] m01;
        logic signed [ELEMENT_BITS-1:0] m02;
        logic signed [ELEMENT_BITS-1:0] m10;
        logic signed [ELEMENT_BITS-1:0] m11;
        logic signed [ELEMENT_BITS-1:0] m12;
        logic signed [ELEMENT_BITS-1:0] m20;
        logic signed [ELEMENT_BITS-1:0] m21;
        logic signed [ELEMENT_BITS-1:0] m22;
    } t_result;

    // Running state of one angle's sine and cosine series.
    typedef struct packed {
        logic                 sneg;
        logic                 flip;
        logic [XW-1:0]        x2;
        logic signed [QW-1:0] ss;
        logic signed [QW-1:0] cs;
        logic [TW-1:0]        st;
        logic [TW-1:0]        ct;
    } t_trig;

    // Fixed settings of one series cell.
    typedef struct packed {
        logic [RW-1:0] sin_recip;
        logic [RW-1:0] cos_recip;
        logic          sub;
    } t_step;

endpackage

@@ design/e2r_fold.sv @@
module e2r_fold import e2r_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [ANGLE_BITS-1:0] i_angle,
    output logic                         o_valid,
    output t_trig                        o_trig
);

    localparam int SQW = 2 * TW;

    logic signed [FW-1:0] n_wide;
    logic signed [FW-1:0] n_folded;
    logic                 n_flip;
    logic [FW-1:0]        n_mag;
    logic [SQW-1:0]       n_square;

    logic          r_fold_valid;
    logic [TW-1:0] r_ax;
    logic          r_sneg;
    logic          r_flip;
    logic          r_trig_valid;
    t_trig         r_trig;

    always_comb begin
        n_wide = {i_angle[ANGLE_BITS-1], i_angle, {ASHIFT{1'b0}}};
        n_flip = 1'b0;
        // Pull the angle into the half circle around zero; sine and
        // cosine change sign with the shift by pi.
        if (n_wide > Q_HALF_PI) begin
            n_folded = n_wide - Q_PI;
            n_flip   = 1'b1;
        end else if (n_wide < -Q_HALF_PI) begin
            n_folded = n_wide + Q_PI;
            n_flip   = 1'b1;
        end else begin
            n_folded = n_wide;
        end
        n_mag    = n_folded[FW-1] ? FW'(-n_folded) : FW'(n_folded);
        n_square = SQW'(r_ax) * SQW'(r_ax);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_valid <= 1'b0;
            r_trig_valid <= 1'b0;
        end else if (i_en) begin
            r_fold_valid <= i_valid;
            r_trig_valid <= r_fold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax      <= n_mag[TW-1:0];
            r_sneg    <= n_folded[FW-1];
            r_flip    <= n_flip;
            r_trig.sneg <= r_sneg;
            r_trig.flip <= r_flip;
            r_trig.x2   <= n_square[QF +: XW];
            r_trig.ss   <= $signed(QW'(r_ax));
            r_trig.cs   <= $signed(QW'(Q_ONE));
            r_trig.st   <= r_ax;
            r_trig.ct   <= Q_ONE;
        end
    end

    assign o_valid = r_trig_valid;
    assign o_trig  = r_trig;

endmodule

@@ design/e2r_cell.sv @@
module e2r_cell import e2r_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_step i_step,
    input  logic  i_valid,
    input  t_trig i_trig,
    output logic  o_valid,
    output t_trig o_trig
);

    localparam int MW   = TW + XW;
    localparam int HW   = NW + RHI;
    localparam int LW   = NW + RLO;
    localparam int SUMW = NW + RLO + 1;

    logic [MW-1:0]   n_prod_s;
    logic [MW-1:0]   n_prod_c;
    logic [SUMW-1:0] n_sum_s;
    logic [SUMW-1:0] n_sum_c;
    logic [TW-1:0]   n_qs;
    logic [TW-1:0]   n_qc;

    logic          r_a_valid;
    t_trig         r_a_trig;
    logic [NW-1:0] r_a_ns;
    logic [NW-1:0] r_a_nc;

    logic          r_b_valid;
    t_trig         r_b_trig;
    logic [HW-1:0] r_b_sh;
    logic [LW-1:0] r_b_sl;
    logic [HW-1:0] r_b_ch;
    logic [LW-1:0] r_b_cl;

    logic  r_c_valid;
    t_trig r_c_trig;

    always_comb begin
        n_prod_s = MW'(i_trig.st) * MW'(i_trig.x2);
        n_prod_c = MW'(i_trig.ct) * MW'(i_trig.x2);
        // The quotient is the reciprocal product shifted down; the low
        // partial product only contributes through its upper bits.
        n_sum_s  = SUMW'(r_b_sh) + SUMW'(r_b_sl >> RLO);
        n_sum_c  = SUMW'(r_b_ch) + SUMW'(r_b_cl >> RLO);
        n_qs     = n_sum_s[RHI +: TW];
        n_qc     = n_sum_c[RHI +: TW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_trig <= i_trig;
            r_a_ns   <= n_prod_s[QF +: NW];
            r_a_nc   <= n_prod_c[QF +: NW];

            r_b_trig <= r_a_trig;
            r_b_sh   <= HW'(r_a_ns) * HW'(i_step.sin_recip[RW-1:RLO]);
            r_b_sl   <= LW'(r_a_ns) * LW'(i_step.sin_recip[RLO-1:0]);
            r_b_ch   <= HW'(r_a_nc) * HW'(i_step.cos_recip[RW-1:RLO]);
            r_b_cl   <= LW'(r_a_nc) * LW'(i_step.cos_recip[RLO-1:0]);

            r_c_trig.sneg <= r_b_trig.sneg;
            r_c_trig.flip <= r_b_trig.flip;
            r_c_trig.x2   <= r_b_trig.x2;
            r_c_trig.st   <= n_qs;
            r_c_trig.ct   <= n_qc;
            if (i_step.sub) begin
                r_c_trig.ss <= r_b_trig.ss - $signed(QW'(n_qs));
                r_c_trig.cs <= r_b_trig.cs - $signed(QW'(n_qc));
            end else begin
                r_c_trig.ss <= r_b_trig.ss + $signed(QW'(n_qs));
                r_c_trig.cs <= r_b_trig.cs + $signed(QW'(n_qc));
            end
        end
    end

    assign o_valid = r_c_valid;
    assign o_trig  = r_c_trig;

endmodule

@@ design/e2r_mix.sv @@
module e2r_mix import e2r_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_trig   i_roll,
    input  t_trig   i_pitch,
    input  t_trig   i_yaw,
    output logic    o_valid,
    output t_result o_res
);

    localparam int PW = 2 * QW;
    localparam int NUM_ELEMS = 9;
    localparam logic [SW:0] EHALF = (SW+1)'((64'd1 << ESH) >> 1);
    localparam logic [SW:0] ELIM  = (SW+1)'(64'd1 << EFRAC);

    // Q30 product, rounded half away from zero.
    function automatic logic signed [QW-1:0] f_mulq(input logic signed [QW-1:0] a,
                                                    input logic signed [QW-1:0] b);
        logic [QW-1:0] ma;
        logic [QW-1:0] mb;
        logic [PW-1:0] p;
        logic [QW-1:0] m;
        ma = a[QW-1] ? QW'(-a) : QW'(a);
        mb = b[QW-1] ? QW'(-b) : QW'(b);
        p  = PW'(ma) * PW'(mb) + (PW'(1) << (QF - 1));
        m  = p[QF +: QW];
        return (a[QW-1] ^ b[QW-1]) ? -$signed(m) : $signed(m);
    endfunction

    // Q30 sum to the element format, rounded and clipped at plus or minus one.
    function automatic logic signed [ELEMENT_BITS-1:0] f_elem(input logic signed [SW-1:0] v);
        logic [SW-1:0]           m;
        logic [SW:0]             r;
        logic [ELEMENT_BITS-1:0] e;
        m = v[SW-1] ? SW'(-v) : SW'(v);
        r = ((SW+1)'(m) + EHALF) >> ESH;
        if (r > ELIM) begin
            r = ELIM;
        end
        e = r[ELEMENT_BITS-1:0];
        return v[SW-1] ? $signed(-e) : $signed(e);
    endfunction

    function automatic logic signed [QW-1:0] f_sin(input t_trig t);
        return (t.sneg ^ t.flip) ? -t.ss : t.ss;
    endfunction

    function automatic logic signed [QW-1:0] f_cos(input t_trig t);
        return t.flip ? -t.cs : t.cs;
    endfunction

    logic [3:0] r_valid;

    logic signed [QW-1:0] r0_sr, r0_cr, r0_sp, r0_cp, r0_sy, r0_cy;

    logic signed [QW-1:0] r1_cycp, r1_sycp, r1_cysp, r1_sysp, r1_sycr;
    logic signed [QW-1:0] r1_sysr, r1_cycr, r1_cysr, r1_cpsr, r1_cpcr;
    logic signed [QW-1:0] r1_sr, r1_cr, r1_sp;

    logic signed [QW-1:0] r2_cyspsr, r2_cyspcr, r2_syspsr, r2_syspcr;
    logic signed [QW-1:0] r2_cycp, r2_sycp, r2_sycr, r2_sysr, r2_cycr;
    logic signed [QW-1:0] r2_cysr, r2_cpsr, r2_cpcr, r2_sp;

    logic signed [SW-1:0] r3_sum [NUM_ELEMS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_sr <= f_sin(i_roll);
            r0_cr <= f_cos(i_roll);
            r0_sp <= f_sin(i_pitch);
            r0_cp <= f_cos(i_pitch);
            r0_sy <= f_sin(i_yaw);
            r0_cy <= f_cos(i_yaw);

            r1_cycp <= f_mulq(r0_cy, r0_cp);
            r1_sycp <= f_mulq(r0_sy, r0_cp);
            r1_cysp <= f_mulq(r0_cy, r0_sp);
            r1_sysp <= f_mulq(r0_sy, r0_sp);
            r1_sycr <= f_mulq(r0_sy, r0_cr);
            r1_sysr <= f_mulq(r0_sy, r0_sr);
            r1_cycr <= f_mulq(r0_cy, r0_cr);
            r1_cysr <= f_mulq(r0_cy, r0_sr);
            r1_cpsr <= f_mulq(r0_cp, r0_sr);
            r1_cpcr <= f_mulq(r0_cp, r0_cr);
            r1_sr   <= r0_sr;
            r1_cr   <= r0_cr;
            r1_sp   <= r0_sp;

            r2_cyspsr <= f_mulq(r1_cysp, r1_sr);
            r2_cyspcr <= f_mulq(r1_cysp, r1_cr);
            r2_syspsr <= f_mulq(r1_sysp, r1_sr);
            r2_syspcr <= f_mulq(r1_sysp, r1_cr);
            r2_cycp   <= r1_cycp;
            r2_sycp   <= r1_sycp;
            r2_sycr   <= r1_sycr;
            r2_sysr   <= r1_sysr;
            r2_cycr   <= r1_cycr;
            r2_cysr   <= r1_cysr;
            r2_cpsr   <= r1_cpsr;
            r2_cpcr   <= r1_cpcr;
            r2_sp     <= r1_sp;

            r3_sum[0] <= SW'(r2_cycp);
            r3_sum[1] <= SW'(r2_cyspsr) - SW'(r2_sycr);
            r3_sum[2] <= SW'(r2_cyspcr) + SW'(r2_sysr);
            r3_sum[3] <= SW'(r2_sycp);
            r3_sum[4] <= SW'(r2_syspsr) + SW'(r2_cycr);
            r3_sum[5] <= SW'(r2_syspcr) - SW'(r2_cysr);
            r3_sum[6] <= -SW'(r2_sp);
            r3_sum[7] <= SW'(r2_cpsr);
            r3_sum[8] <= SW'(r2_cpcr);
        end
    end

    always_comb begin
        o_res.m00 = f_elem(r3_sum[0]);
        o_res.m01 = f_elem(r3_sum[1]);
        o_res.m02 = f_elem(r3_sum[2]);
        o_res.m10 = f_elem(r3_sum[3]);
        o_res.m11 = f_elem(r3_sum[4]);
        o_res.m12 = f_elem(r3_sum[5]);
        o_res.m20 = f_elem(r3_sum[6]);
        o_res.m21 = f_elem(r3_sum[7]);
        o_res.m22 = f_elem(r3_sum[8]);
    end

    assign o_valid = r_valid[3];

endmodule

@@ design/euler_to_rotation_matrix.sv @@
// Converts one roll, pitch and yaw request (radians, 13 fraction bits) into the nine
// elements of the Z-Y-X rotation matrix (14 fraction bits, clipped to plus or minus one).
// A new request is taken every clock cycle while o_stall is low. On its way to the output
// it passes the row of fifteen series cells per angle, each three register stages deep
// (term product, reciprocal partial products, quotient and running sum), with two
// fold-and-square stages in front, four product and rounding stages behind, and the
// output register. The output holds up to two finished results; o_stall rises only when
// both are waiting.
module euler_to_rotation_matrix import e2r_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_request i_req,
    output logic     o_valid,
    input  logic     i_stall,
    output t_result  o_res
);

    localparam int NUM_AXES = 3;
    localparam int ROLL     = 0;
    localparam int PITCH    = 1;
    localparam int YAW      = 2;
    localparam int LAST     = TRIG_STEPS - 1;

    logic signed [ANGLE_BITS-1:0] w_angle [NUM_AXES];
    t_trig                        w_trig  [NUM_AXES][TRIG_STEPS];
    logic                         w_valid [NUM_AXES][TRIG_STEPS];

    logic    w_en;
    logic    w_take;
    logic    w_arrive;
    logic    w_mix_valid;
    t_result w_mix_res;

    logic    n_out_valid;
    logic    n_skid_valid;
    t_result n_out_res;
    t_result n_skid_res;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_res;
    t_result r_skid_res;

    assign w_angle[ROLL]  = i_req.roll_angle;
    assign w_angle[PITCH] = i_req.pitch_angle;
    assign w_angle[YAW]   = i_req.yaw_angle;

    // The whole pipeline moves unless a second result is parked in the skid register.
    assign w_en = !r_skid_valid;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        e2r_fold u_fold (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (i_valid),
            .i_angle (w_angle[a]),
            .o_valid (w_valid[a][0]),
            .o_trig  (w_trig[a][0])
        );
    end

    for (genvar k = 1; k < TRIG_STEPS; k++) begin : g_step
        localparam longint unsigned SIN_DIV = longint'((2 * k) * (2 * k + 1));
        localparam longint unsigned COS_DIV = longint'((2 * k - 1) * (2 * k));
        localparam logic [RW-1:0] SIN_RECIP =
            RW'(((64'd1 << RSH) + SIN_DIV - 64'd1) / SIN_DIV);
        localparam logic [RW-1:0] COS_RECIP =
            RW'(((64'd1 << RSH) + COS_DIV - 64'd1) / COS_DIV);

        t_step w_step;
        assign w_step = '{sin_recip: SIN_RECIP, cos_recip: COS_RECIP,
                          sub: ((k % 2) == 1)};

        for (genvar a = 0; a < NUM_AXES; a++) begin : g_cell
            e2r_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_step  (w_step),
                .i_valid (w_valid[a][k-1]),
                .i_trig  (w_trig[a][k-1]),
                .o_valid (w_valid[a][k]),
                .o_trig  (w_trig[a][k])
            );
        end
    end

    e2r_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[ROLL][LAST] & w_valid[PITCH][LAST] & w_valid[YAW][LAST]),
        .i_roll  (w_trig[ROLL][LAST]),
        .i_pitch (w_trig[PITCH][LAST]),
        .i_yaw   (w_trig[YAW][LAST]),
        .o_valid (w_mix_valid),
        .o_res   (w_mix_res)
    );

    assign w_take   = r_out_valid && !i_stall;
    assign w_arrive = w_en && w_mix_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_res    = r_out_res;
        n_skid_res   = r_skid_res;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out_valid  = 1'b1;
                n_out_res    = r_skid_res;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || w_take) begin
            n_out_valid = w_arrive;
            n_out_res   = w_mix_res;
        end else if (w_arrive) begin
            n_skid_valid = 1'b1;
            n_skid_res   = w_mix_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_res  <= n_out_res;
        r_skid_res <= n_skid_res;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out_res;
    assign o_stall = r_skid_valid;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid register filled while the output was free");

    a_m00_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.m00 <= ELEM_ONE && o_res.m00 >= -ELEM_ONE))
        else $error("m00 outside plus or minus one");

    a_m20_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.m20 <= ELEM_ONE && o_res.m20 >= -ELEM_ONE))
        else $error("m20 outside plus or minus one");

endmodule
